@@ rtl/bdt_pkg.sv @@
// ----------------------------------------------------------------------------
// bdt_pkg
// Shared types and constants for the binary to decimal text converter.
// ----------------------------------------------------------------------------
package bdt_pkg;

	localparam int MANT_W      = 96;
	localparam int LOW_W       = 64;
	localparam int HIGH_W      = 32;
	localparam int SCALE_W     = 5;
	localparam int DIGITS      = 29;
	localparam int DIGIT_IDX_W = 5;
	localparam int BIT_CNT_W   = 7;
	localparam int CHAR_W      = 8;
	localparam int IN_DATA_W   = 104;
	localparam int OUT_DATA_W  = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [SCALE_W-1:0] SCALE_MAX = 5'd28;

	localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_DOT     = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

	// one number waiting for conversion; bit layout matches s_axis_tdata
	typedef struct packed {
		logic               negative;
		logic [SCALE_W-1:0] scale;
		logic [MANT_W-1:0]  mantissa;
	} item_t;

endpackage

@@ rtl/binary_to_decimal_text.sv @@
// ----------------------------------------------------------------------------
// binary_to_decimal_text
// Prints a signed, scaled 96-bit integer as ASCII decimal text.
// ----------------------------------------------------------------------------
// Input stream s_axis: one transaction carries a 96-bit unsigned mantissa,
// a scale (digits after the point, values above 28 act as 28) and a sign.
// Output stream m_axis: one character per transaction: optional '-', the
// digits with '.' before the last scale digits (zero padded to scale+1
// digits), then a newline with tlast high.
// A popped item runs through the bit-serial double dabble loop, one step per
// mantissa bit (all 29 digits updated each cycle), then a step to find the top
// digit, then emits one character per cycle while m_axis accepts, up to 32.
// The converter takes the next item only after its newline is loaded.
// The input register and a QUEUE_DEPTH entry queue keep accepting items
// while the converter works. A stall on m_axis holds the output register and
// the emitting converter; back pressure reaches s_axis only once the queue and
// input register are full. Reset empties the queue and idles the converter.
// ----------------------------------------------------------------------------
module binary_to_decimal_text #(
	parameter int QUEUE_DEPTH = bdt_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [63:0] mantissa_low, [95:64] mantissa_high, [100:96] scale,
	// [101] negative, [103:102] zero
	input  logic [bdt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [7:0] character
	output logic [bdt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tlast
);

	logic           push_valid;
	logic           push_ready;
	bdt_pkg::item_t push_item;
	logic           pop_valid;
	logic           pop_ready;
	bdt_pkg::item_t pop_item;

	bdt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	bdt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_item  (push_item),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_item  (pop_item)
	);

	bdt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (pop_valid),
		.item_ready (pop_ready),
		.item       (pop_item),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_char   (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

endmodule

@@ rtl/bdt_front.sv @@
// ----------------------------------------------------------------------------
// bdt_front
// Input stage: takes a transaction, saturates the scale and holds the item
// until the queue has room.
// ----------------------------------------------------------------------------
module bdt_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bdt_pkg::IN_DATA_W-1:0]    in_data,
	output logic                             push_valid,
	input  logic                             push_ready,
	output bdt_pkg::item_t                   push_item
);

	logic            valid_q;
	bdt_pkg::item_t  item_q;
	logic [bdt_pkg::SCALE_W-1:0] scale_in;
	logic            take;

	assign scale_in = in_data[bdt_pkg::MANT_W +: bdt_pkg::SCALE_W];
	assign in_ready = !valid_q || push_ready;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (push_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q.mantissa <= in_data[bdt_pkg::MANT_W-1:0];
			item_q.scale    <= (scale_in > bdt_pkg::SCALE_MAX) ? bdt_pkg::SCALE_MAX : scale_in;
			item_q.negative <= in_data[bdt_pkg::MANT_W + bdt_pkg::SCALE_W];
		end
	end

	assign push_valid = valid_q;
	assign push_item  = item_q;

endmodule

@@ rtl/bdt_queue.sv @@
// ----------------------------------------------------------------------------
// bdt_queue
// Short FIFO between the input stage and the converter.
// ----------------------------------------------------------------------------
module bdt_queue #(
	parameter int DEPTH = bdt_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  bdt_pkg::item_t wr_item,
	output logic           rd_valid,
	input  logic           rd_ready,
	output bdt_pkg::item_t rd_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bdt_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = count_q != CNT_W'(DEPTH);
	assign rd_valid = count_q != '0;
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

@@ rtl/bdt_back.sv @@
// ----------------------------------------------------------------------------
// bdt_back
// Converter: double dabble over 96 bit steps, then one character per cycle
// into a registered output while that register is free.
// ----------------------------------------------------------------------------
module bdt_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  bdt_pkg::item_t                    item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bdt_pkg::CHAR_W-1:0]        out_char,
	output logic                              out_last
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_LEN,
		ST_SIGN,
		ST_DIGIT,
		ST_NEWLINE
	} state_t;

	state_t                          state_q;
	logic [bdt_pkg::MANT_W-1:0]      mant_q;
	logic [bdt_pkg::SCALE_W-1:0]     scale_q;
	logic                            neg_q;
	logic [bdt_pkg::BIT_CNT_W-1:0]   bit_cnt_q;
	logic [3:0]                      digit_q [bdt_pkg::DIGITS];
	logic [bdt_pkg::DIGIT_IDX_W-1:0] pos_q;
	logic                            dot_done_q;
	logic                            out_valid_q;
	logic [bdt_pkg::CHAR_W-1:0]      out_char_q;
	logic                            out_last_q;

	logic [3:0]                      digit_nxt [bdt_pkg::DIGITS];
	logic [bdt_pkg::DIGIT_IDX_W-1:0] msd;
	logic                            out_free;
	logic                            emit;
	logic                            dot_here;
	logic [3:0]                      cur_digit;

	assign out_free   = !out_valid_q || out_ready;
	assign item_ready = state_q == ST_IDLE;
	// a character is loaded into the output register this cycle
	assign emit       = out_free && (state_q == ST_SIGN || state_q == ST_DIGIT ||
		state_q == ST_NEWLINE);

	// doubling with carry: a digit's carry out depends only on itself (>= 5)
	always_comb begin
		for (int k = 0; k < bdt_pkg::DIGITS; k++) begin
			logic cin;
			cin = (k == 0) ? mant_q[bdt_pkg::MANT_W-1] : (digit_q[k-1] >= 4'd5);
			if (digit_q[k] >= 4'd5) begin
				digit_nxt[k] = 4'((digit_q[k] << 1) - 4'd10) | {3'b000, cin};
			end else begin
				digit_nxt[k] = 4'(digit_q[k] << 1) | {3'b000, cin};
			end
		end
	end

	// highest nonzero digit, zero when all digits are zero
	always_comb begin
		msd = '0;
		for (int k = 1; k < bdt_pkg::DIGITS; k++) begin
			if (digit_q[k] != 4'd0) begin
				msd = bdt_pkg::DIGIT_IDX_W'(k);
			end
		end
	end

	assign cur_digit = digit_q[pos_q];
	assign dot_here  = !dot_done_q && (scale_q != '0) &&
		((pos_q + bdt_pkg::DIGIT_IDX_W'(1)) == scale_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
			bit_cnt_q   <= '0;
			pos_q       <= '0;
			dot_done_q  <= 1'b0;
		end else begin
			if (out_ready && !emit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						bit_cnt_q  <= bdt_pkg::BIT_CNT_W'(bdt_pkg::MANT_W - 1);
						dot_done_q <= 1'b0;
						state_q    <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == '0) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					// first printed position: max of top digit and scale
					pos_q   <= (msd > scale_q) ? msd : scale_q;
					state_q <= neg_q ? ST_SIGN : ST_DIGIT;
				end
				ST_SIGN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= bdt_pkg::CHAR_MINUS;
						out_last_q  <= 1'b0;
						state_q     <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_last_q  <= 1'b0;
						if (dot_here) begin
							out_char_q <= bdt_pkg::CHAR_DOT;
							dot_done_q <= 1'b1;
						end else begin
							out_char_q <= bdt_pkg::CHAR_ZERO | {4'h0, cur_digit};
							if (pos_q == '0) begin
								state_q <= ST_NEWLINE;
							end else begin
								pos_q <= pos_q - 1'b1;
							end
						end
					end
				end
				ST_NEWLINE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= bdt_pkg::CHAR_NEWLINE;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			mant_q  <= item.mantissa;
			scale_q <= item.scale;
			neg_q   <= item.negative;
			for (int k = 0; k < bdt_pkg::DIGITS; k++) begin
				digit_q[k] <= 4'd0;
			end
		end else if (state_q == ST_CONV) begin
			mant_q <= mant_q << 1;
			for (int k = 0; k < bdt_pkg::DIGITS; k++) begin
				digit_q[k] <= digit_nxt[k];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule

@@ bench/decimal_text_checker.sv @@
// ----------------------------------------------------------------------------
// decimal_text_checker
// Watches both streams of the decimal text converter and checks every
// character against text predicted from the accepted numbers.
// ----------------------------------------------------------------------------
module decimal_text_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [bdt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [bdt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                           m_axis_tlast,
	output int                             failures,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import bdt_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} text_char_t;

	text_char_t expected_chars[$];

	initial begin
		failures = 0;
		pending  = 0;
	end

	task automatic report_mismatch(input string msg);
		if (failures < 50) begin
			$display("%0t ns: mismatch: %s", $time, msg);
		end
		failures++;
	endtask

	task automatic push_char(input logic [CHAR_W-1:0] c, input logic last);
		text_char_t tc;
		tc.character = c;
		tc.last      = last;
		expected_chars.push_back(tc);
	endtask

	// Digits by repeated division; the text is built the way the block prints it.
	task automatic predict_text(input item_t num);
		logic [3:0]         digit [DIGITS];
		logic [MANT_W-1:0]  rest;
		logic [SCALE_W-1:0] sc;
		int                 len;
		int                 k;
		rest = num.mantissa;
		for (k = 0; k < DIGITS; k++) begin
			digit[k] = 4'(rest % 10);
			rest     = rest / 10;
		end
		sc  = (num.scale > SCALE_MAX) ? SCALE_MAX : num.scale;
		len = 1;
		for (k = 1; k < DIGITS; k++) begin
			if (digit[k] != 4'd0) len = k + 1;
		end
		if (int'(sc) >= len) len = int'(sc) + 1;
		if (num.negative) push_char(CHAR_MINUS, 1'b0);
		for (k = len - 1; k >= 0; k--) begin
			if (sc != '0 && k == int'(sc) - 1) push_char(CHAR_DOT, 1'b0);
			push_char(CHAR_ZERO + CHAR_W'(digit[k]), 1'b0);
		end
		push_char(CHAR_NEWLINE, 1'b1);
	endtask

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_text(item_t'(s_axis_tdata[$bits(item_t)-1:0]));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected character %h", m_axis_tdata));
				end else begin
					want = expected_chars.pop_front();
					if (m_axis_tdata !== want.character) begin
						report_mismatch($sformatf("character %h, expected %h",
							m_axis_tdata, want.character));
					end
					if (m_axis_tlast !== want.last) begin
						report_mismatch($sformatf("tlast %b, expected %b on character %h",
							m_axis_tlast, want.last, want.character));
					end
				end
			end
			pending <= expected_chars.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives numbers into the decimal text converter: directed corner cases,
// then random mantissas of spread magnitude, scales and signs, with random
// gaps on both streams and one long output stall. The checker does the
// comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bdt_pkg::*;

	localparam logic [MANT_W-1:0] ALL_ONES  = {MANT_W{1'b1}};
	localparam logic [MANT_W-1:0] TEN_POW28 = 96'd10000000000000000000000000000;
	localparam int RANDOM_NUMBERS = 330;
	localparam int HOLD_CYCLES    = 1500;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	int                    failures;
	int                    pending;

	bit sender_idles;
	bit receiver_idles;
	bit hold_output;

	binary_to_decimal_text dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	decimal_text_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.failures      (failures),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// Output side: random back pressure, plus one long hold-off on request.
	initial begin
		m_axis_tready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			@(posedge clk);
			if (hold_output) begin
				hold_output = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= !(receiver_idles && $urandom_range(99) < 22);
		end
	end

	task automatic send_number(input logic [MANT_W-1:0] mant,
			input logic [SCALE_W-1:0] sc, input logic neg);
		item_t num;
		num.mantissa = mant;
		num.scale    = sc;
		num.negative = neg;
		while (sender_idles && $urandom_range(99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_DATA_W'(num);
		do @(posedge clk); while (!s_axis_tready);
	endtask

	initial begin
		logic [MANT_W-1:0]  mant;
		logic [SCALE_W-1:0] sc;
		int                 n;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		hold_output    = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner cases: zero, widest value, scale saturation and padding
		send_number('0, 5'd0, 1'b0);
		send_number('0, 5'd0, 1'b1);
		send_number('0, 5'd5, 1'b0);
		send_number('0, 5'd31, 1'b1);
		send_number(ALL_ONES, 5'd0, 1'b1);
		send_number(ALL_ONES, 5'd28, 1'b1);
		send_number(ALL_ONES, 5'd29, 1'b0);
		send_number(ALL_ONES, 5'd31, 1'b1);
		send_number(96'd1, 5'd28, 1'b0);
		send_number(96'd1, 5'd30, 1'b1);
		send_number(96'd1, 5'd1, 1'b0);
		send_number(96'd12345, 5'd5, 1'b0);
		send_number(96'd12345, 5'd4, 1'b1);
		send_number(96'd12345, 5'd6, 1'b0);
		send_number(96'd9, 5'd0, 1'b0);
		send_number(96'd10, 5'd1, 1'b1);
		send_number(TEN_POW28, 5'd28, 1'b0);
		send_number(TEN_POW28 - 1, 5'd28, 1'b1);
		send_number(TEN_POW28, 5'd0, 1'b0);
		send_number({32'h0, {64{1'b1}}}, 5'd16, 1'b0);
		send_number({{32{1'b1}}, 64'h0}, 5'd2, 1'b1);
		send_number({24{4'hA}}, 5'd12, 1'b0);
		send_number({24{4'h5}}, 5'd27, 1'b1);

		// long output stall while input keeps coming: fills queue, blocks s_axis
		hold_output = 1'b1;
		for (n = 0; n < RANDOM_NUMBERS; n++) begin
			// middle stretch with no gaps on either side
			sender_idles   = !(n >= 140 && n < 200);
			receiver_idles = !(n >= 140 && n < 200);
			mant = {$urandom(), $urandom(), $urandom()};
			if ($urandom_range(9) != 0) mant = mant >> $urandom_range(95);
			if ($urandom_range(9) == 0) sc = 5'($urandom_range(31, 29));
			else sc = 5'($urandom_range(28));
			send_number(mant, sc, 1'($urandom_range(1)));
		end
		s_axis_tvalid  <= 1'b0;
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/bdt_pkg.sv
rtl/bdt_front.sv
rtl/bdt_queue.sv
rtl/bdt_back.sv
rtl/binary_to_decimal_text.sv
bench/decimal_text_checker.sv
bench/testbench.sv
